[src/ocvs_pkg.sv]
// ocvs_pkg: widths, range codes, state types, control structs and the ocv rom
// shared by the ocv to soc interpolator; depends on nothing
package ocvs_pkg;

   localparam int VOLT_BITS   = 16;
   localparam int SOC_BITS    = 10;
   localparam int PROD_BITS   = VOLT_BITS + SOC_BITS;
   localparam int ROM_ENTRIES = 164;
   localparam int IDX_BITS    = $clog2(ROM_ENTRIES);
   localparam int COUNT_BITS  = $clog2(SOC_BITS);

   localparam logic [SOC_BITS-1:0]  SOC_FULL   = SOC_BITS'(1000);
   localparam logic [VOLT_BITS-1:0] UV_DEFAULT = VOLT_BITS'(30000);

   typedef enum logic [1:0] {
      RANGE_INTERP = 2'd0,
      RANGE_UNDER  = 2'd1,
      RANGE_BELOW  = 2'd2,
      RANGE_ABOVE  = 2'd3
   } range_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_ARITH,
      ST_HOLD
   } ctrl_state_type;

   typedef enum logic [1:0] {
      AR_IDLE,
      AR_MUL,
      AR_DIV
   } arith_state_type;

   typedef struct packed {
      logic                 start;
      logic [VOLT_BITS-1:0] voltage;
      logic [IDX_BITS-1:0]  last;
   } search_cmd_type;

   typedef struct packed {
      logic                done;
      logic [IDX_BITS-1:0] index;
   } search_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [VOLT_BITS-1:0] voltage;
      logic [IDX_BITS-1:0]  index;
   } arith_cmd_type;

   typedef struct packed {
      logic                done;
      logic [SOC_BITS-1:0] soc;
   } arith_rsp_type;

   localparam logic [VOLT_BITS-1:0] ROM_VOLT [ROM_ENTRIES] = '{
      16'd32384, 16'd33406, 16'd34121, 16'd34674, 16'd35125, 16'd35504,
      16'd35829, 16'd36113, 16'd36362, 16'd36578, 16'd36744, 16'd36830,
      16'd36868, 16'd36890, 16'd36905, 16'd36916, 16'd36925, 16'd36933,
      16'd36941, 16'd36950, 16'd36961, 16'd36981, 16'd37021, 16'd37070,
      16'd37113, 16'd37149, 16'd37179, 16'd37205, 16'd37231, 16'd37258,
      16'd37288, 16'd37320, 16'd37350, 16'd37378, 16'd37403, 16'd37425,
      16'd37445, 16'd37464, 16'd37481, 16'd37498, 16'd37515, 16'd37534,
      16'd37554, 16'd37576, 16'd37598, 16'd37619, 16'd37639, 16'd37657,
      16'd37673, 16'd37687, 16'd37700, 16'd37712, 16'd37723, 16'd37734,
      16'd37744, 16'd37754, 16'd37765, 16'd37777, 16'd37789, 16'd37802,
      16'd37815, 16'd37828, 16'd37842, 16'd37855, 16'd37869, 16'd37883,
      16'd37898, 16'd37912, 16'd37927, 16'd37942, 16'd37958, 16'd37973,
      16'd37989, 16'd38006, 16'd38023, 16'd38040, 16'd38057, 16'd38075,
      16'd38094, 16'd38112, 16'd38132, 16'd38151, 16'd38172, 16'd38193,
      16'd38214, 16'd38236, 16'd38258, 16'd38281, 16'd38305, 16'd38329,
      16'd38355, 16'd38381, 16'd38407, 16'd38435, 16'd38464, 16'd38494,
      16'd38525, 16'd38557, 16'd38590, 16'd38625, 16'd38661, 16'd38698,
      16'd38738, 16'd38779, 16'd38822, 16'd38866, 16'd38912, 16'd38959,
      16'd39007, 16'd39055, 16'd39102, 16'd39148, 16'd39193, 16'd39236,
      16'd39279, 16'd39320, 16'd39360, 16'd39400, 16'd39439, 16'd39476,
      16'd39510, 16'd39541, 16'd39570, 16'd39595, 16'd39619, 16'd39643,
      16'd39668, 16'd39697, 16'd39728, 16'd39762, 16'd39799, 16'd39839,
      16'd39883, 16'd39933, 16'd39988, 16'd40051, 16'd40123, 16'd40207,
      16'd40303, 16'd40404, 16'd40506, 16'd40600, 16'd40678, 16'd40737,
      16'd40782, 16'd40814, 16'd40839, 16'd40862, 16'd40892, 16'd40934,
      16'd40981, 16'd41031, 16'd41083, 16'd41136, 16'd41191, 16'd41246,
      16'd41301, 16'd41357, 16'd41413, 16'd41469, 16'd41527, 16'd41585,
      16'd41646, 16'd41667
   };

   localparam logic [SOC_BITS-1:0] ROM_SOC [ROM_ENTRIES] = '{
      10'd5,   10'd11,  10'd17,  10'd23,  10'd29,  10'd35,
      10'd41,  10'd47,  10'd53,  10'd60,  10'd66,  10'd72,
      10'd78,  10'd84,  10'd90,  10'd96,  10'd102, 10'd108,
      10'd115, 10'd121, 10'd127, 10'd133, 10'd139, 10'd145,
      10'd151, 10'd157, 10'd163, 10'd169, 10'd176, 10'd182,
      10'd188, 10'd194, 10'd200, 10'd206, 10'd212, 10'd218,
      10'd224, 10'd231, 10'd237, 10'd243, 10'd249, 10'd255,
      10'd261, 10'd267, 10'd273, 10'd279, 10'd285, 10'd292,
      10'd298, 10'd304, 10'd310, 10'd316, 10'd322, 10'd328,
      10'd334, 10'd340, 10'd347, 10'd353, 10'd359, 10'd365,
      10'd371, 10'd377, 10'd383, 10'd389, 10'd395, 10'd402,
      10'd408, 10'd414, 10'd420, 10'd426, 10'd432, 10'd438,
      10'd444, 10'd450, 10'd456, 10'd463, 10'd469, 10'd475,
      10'd481, 10'd487, 10'd493, 10'd499, 10'd505, 10'd511,
      10'd518, 10'd524, 10'd530, 10'd536, 10'd542, 10'd548,
      10'd554, 10'd560, 10'd566, 10'd573, 10'd579, 10'd585,
      10'd591, 10'd597, 10'd603, 10'd609, 10'd615, 10'd621,
      10'd627, 10'd634, 10'd640, 10'd646, 10'd652, 10'd658,
      10'd664, 10'd670, 10'd676, 10'd682, 10'd689, 10'd695,
      10'd701, 10'd707, 10'd713, 10'd719, 10'd725, 10'd731,
      10'd737, 10'd744, 10'd750, 10'd756, 10'd762, 10'd768,
      10'd774, 10'd780, 10'd786, 10'd792, 10'd798, 10'd805,
      10'd811, 10'd817, 10'd823, 10'd829, 10'd835, 10'd841,
      10'd847, 10'd853, 10'd860, 10'd866, 10'd872, 10'd878,
      10'd884, 10'd890, 10'd896, 10'd902, 10'd908, 10'd915,
      10'd921, 10'd927, 10'd933, 10'd939, 10'd945, 10'd951,
      10'd957, 10'd963, 10'd969, 10'd976, 10'd982, 10'd988,
      10'd994, 10'd1000
   };

endpackage

[src/ocvs_if.sv]
// ocvs_req_if and ocvs_rsp_if: valid/ready channels for the interpolator
// depends on ocvs_pkg for field widths
interface ocvs_req_if;
   logic                           valid;
   logic                           ready;
   logic [ocvs_pkg::VOLT_BITS-1:0] cell_voltage;
   logic                           sample_valid;

   modport source(output valid, cell_voltage, sample_valid, input ready);
   modport sink(input valid, cell_voltage, sample_valid, output ready);
endinterface

interface ocvs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ocvs_pkg::SOC_BITS-1:0] soc_tenths;
   logic                          soc_valid;
   logic [1:0]                    range_status;

   modport source(output valid, soc_tenths, soc_valid, range_status, input ready);
   modport sink(input valid, soc_tenths, soc_valid, range_status, output ready);
endinterface

[src/ocvs_search.sv]
// ocvs_search: iterative binary search of the ocv rom for the segment holding a voltage
// depends on ocvs_pkg for the rom and the control structs
module ocvs_search (
   input  logic                     clock,
   input  logic                     reset,
   input  ocvs_pkg::search_cmd_type cmd,
   output ocvs_pkg::search_rsp_type rsp
);

   localparam int IDX = ocvs_pkg::IDX_BITS;

   logic                           busy_ff, busy_in;
   logic [IDX-1:0]                 lo_ff, lo_in;
   logic [IDX-1:0]                 hi_ff, hi_in;
   logic [ocvs_pkg::VOLT_BITS-1:0] volt_ff, volt_in;
   logic [IDX:0]                   sum;
   logic [IDX-1:0]                 mid;
   logic                           adjacent;

   assign sum      = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = sum[IDX:1];
   assign adjacent = (hi_ff == lo_ff + IDX'(1));

   always_comb begin
      busy_in = busy_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      volt_in = volt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         lo_in   = '0;
         hi_in   = cmd.last;
         volt_in = cmd.voltage;
      end else if (busy_ff) begin
         if (adjacent) begin
            busy_in = 1'b0;
         end else if (ocvs_pkg::ROM_VOLT[mid] <= volt_ff) begin
            lo_in = mid;
         end else begin
            hi_in = mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      volt_ff <= volt_in;
   end

   assign rsp.done  = busy_ff && adjacent;
   assign rsp.index = lo_ff;

   // the bracket stays ordered and holds the voltage
   a_bracket_order: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (lo_ff < hi_ff))
      else $error("search bracket collapsed");

   a_bracket_low: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (ocvs_pkg::ROM_VOLT[lo_ff] <= volt_ff))
      else $error("voltage below lower bracket point");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("search started while busy");

endmodule

[src/ocvs_arith.sv]
// ocvs_arith: bit-serial multiply then restoring divide for the segment interpolation
// depends on ocvs_pkg for the rom, widths and control structs
module ocvs_arith (
   input  logic                    clock,
   input  logic                    reset,
   input  ocvs_pkg::arith_cmd_type cmd,
   output ocvs_pkg::arith_rsp_type rsp
);

   localparam int VB  = ocvs_pkg::VOLT_BITS;
   localparam int SB  = ocvs_pkg::SOC_BITS;
   localparam int PB  = ocvs_pkg::PROD_BITS;
   localparam int CB  = ocvs_pkg::COUNT_BITS;
   localparam int IDX = ocvs_pkg::IDX_BITS;

   ocvs_pkg::arith_state_type state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic [SB-1:0] mplier_ff, mplier_in;
   logic [VB-1:0] dv_ff, dv_in;
   logic [PB-1:0] dsh_ff, dsh_in;
   logic [PB-1:0] acc_ff, acc_in;
   logic [SB-1:0] q_ff, q_in;
   logic [SB-1:0] y0_ff, y0_in;
   logic          down_ff, down_in;
   logic          flat_ff, flat_in;
   logic          done_ff, done_in;
   logic [SB-1:0] soc_ff, soc_in;

   logic [IDX-1:0] idx_next;
   logic [VB-1:0]  x0, x1, dx;
   logic [SB-1:0]  y0, y1;
   logic           qbit;
   logic [SB-1:0]  q_full;
   logic [SB:0]    sum;
   logic           last_step;

   assign idx_next  = cmd.index + IDX'(1);
   assign x0        = ocvs_pkg::ROM_VOLT[cmd.index];
   assign x1        = ocvs_pkg::ROM_VOLT[idx_next];
   assign y0        = ocvs_pkg::ROM_SOC[cmd.index];
   assign y1        = ocvs_pkg::ROM_SOC[idx_next];
   assign dx        = x1 - x0;
   assign qbit      = (acc_ff >= dsh_ff);
   assign q_full    = {q_ff[SB-2:0], qbit};
   assign last_step = (count_ff == CB'(SB - 1));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      mplier_in = mplier_ff;
      dv_in     = dv_ff;
      dsh_in    = dsh_ff;
      acc_in    = acc_ff;
      q_in      = q_ff;
      y0_in     = y0_ff;
      down_in   = down_ff;
      flat_in   = flat_ff;
      done_in   = 1'b0;
      soc_in    = soc_ff;
      sum       = '0;
      case (state_ff)
         ocvs_pkg::AR_IDLE: begin
            if (cmd.start) begin
               state_in  = ocvs_pkg::AR_MUL;
               count_in  = '0;
               dv_in     = cmd.voltage - x0;
               dsh_in    = PB'(dx) << (SB - 1);
               acc_in    = '0;
               q_in      = '0;
               y0_in     = y0;
               down_in   = (y1 < y0);
               flat_in   = (x1 <= x0);
               mplier_in = (y1 < y0) ? (y0 - y1) : (y1 - y0);
            end
         end
         ocvs_pkg::AR_MUL: begin
            acc_in    = (acc_ff << 1) + (mplier_ff[SB-1] ? PB'(dv_ff) : PB'(0));
            mplier_in = mplier_ff << 1;
            count_in  = count_ff + CB'(1);
            if (last_step) begin
               state_in = ocvs_pkg::AR_DIV;
               count_in = '0;
            end
         end
         ocvs_pkg::AR_DIV: begin
            if (qbit) begin
               acc_in = acc_ff - dsh_ff;
            end
            dsh_in   = dsh_ff >> 1;
            q_in     = q_full;
            count_in = count_ff + CB'(1);
            if (last_step) begin
               state_in = ocvs_pkg::AR_IDLE;
               done_in  = 1'b1;
               if (flat_ff) begin
                  soc_in = y0_ff;
               end else begin
                  if (down_ff) begin
                     sum = {1'b0, y0_ff} - {1'b0, q_full};
                  end else begin
                     sum = {1'b0, y0_ff} + {1'b0, q_full};
                  end
                  soc_in = (sum > {1'b0, ocvs_pkg::SOC_FULL}) ? ocvs_pkg::SOC_FULL : sum[SB-1:0];
               end
            end
         end
         default: begin
            state_in = ocvs_pkg::AR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ocvs_pkg::AR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      count_ff  <= count_in;
      mplier_ff <= mplier_in;
      dv_ff     <= dv_in;
      dsh_ff    <= dsh_in;
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      y0_ff     <= y0_in;
      down_ff   <= down_in;
      flat_ff   <= flat_in;
      soc_ff    <= soc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.soc  = soc_ff;

   // remainder stays under twice the current divisor step
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ocvs_pkg::AR_DIV && !flat_ff) |-> ((acc_ff >> 1) < dsh_ff))
      else $error("quotient overflow in divide");

   a_done_after_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(state_ff) == ocvs_pkg::AR_DIV))
      else $error("done without a divide");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (state_ff == ocvs_pkg::AR_IDLE))
      else $error("arith started while busy");

endmodule

[src/ocv_to_soc_interpolator_top.sv]
// ocv_to_soc_interpolator_top: control, threshold register and result register
// depends on ocvs_pkg, ocvs_if, ocvs_search and ocvs_arith
// an invalid, under threshold or out of table voltage passes from the check state straight to the
// hold state; an interpolated one first runs the search, then the bit-serial multiply and divide
// a request is taken only in the idle state, not while one is still in work; a new request is
// taken while a result waits; reset: synchronous, threshold returns to 30000, no result pending
module ocv_to_soc_interpolator_top #(
   parameter int TABLE_POINTS = 164
) (
   input  logic                           clock,
   input  logic                           reset,
   ocvs_req_if.sink                       req_chan,
   ocvs_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [ocvs_pkg::VOLT_BITS-1:0] csr_write_data
);

   localparam int IDX    = ocvs_pkg::IDX_BITS;
   localparam int POINTS = (TABLE_POINTS > ocvs_pkg::ROM_ENTRIES) ?
                           ocvs_pkg::ROM_ENTRIES : TABLE_POINTS;
   localparam int LAST   = (POINTS < 2) ? 1 : POINTS - 1;
   localparam logic [IDX-1:0] LAST_INDEX = IDX'(LAST);
   localparam bit SHORT_TABLE = (POINTS < 2);

   ocvs_pkg::ctrl_state_type state_ff, state_in;
   logic [ocvs_pkg::VOLT_BITS-1:0] thr_ff, thr_in;
   logic [ocvs_pkg::VOLT_BITS-1:0] volt_ff, volt_in;
   logic                           sv_ff, sv_in;
   logic [ocvs_pkg::SOC_BITS-1:0]  res_soc_ff, res_soc_in;
   ocvs_pkg::range_type            res_status_ff, res_status_in;
   logic                           out_valid_ff, out_valid_in;
   logic [ocvs_pkg::SOC_BITS-1:0]  out_soc_ff, out_soc_in;
   logic                           out_sv_ff, out_sv_in;
   ocvs_pkg::range_type            out_status_ff, out_status_in;

   ocvs_pkg::search_cmd_type search_cmd;
   ocvs_pkg::search_rsp_type search_rsp;
   ocvs_pkg::arith_cmd_type  arith_cmd;
   ocvs_pkg::arith_rsp_type  arith_rsp;
   logic                     load_out;

   ocvs_search u_search (
      .clock (clock),
      .reset (reset),
      .cmd   (search_cmd),
      .rsp   (search_rsp)
   );

   ocvs_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .rsp   (arith_rsp)
   );

   assign thr_in = csr_write_enable ? csr_write_data : thr_ff;

   always_comb begin
      state_in          = state_ff;
      volt_in           = volt_ff;
      sv_in             = sv_ff;
      res_soc_in        = res_soc_ff;
      res_status_in     = res_status_ff;
      search_cmd.start   = 1'b0;
      search_cmd.voltage = volt_ff;
      search_cmd.last    = LAST_INDEX;
      arith_cmd.start    = 1'b0;
      arith_cmd.voltage  = volt_ff;
      arith_cmd.index    = search_rsp.index;
      load_out          = 1'b0;
      case (state_ff)
         ocvs_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               volt_in  = req_chan.cell_voltage;
               sv_in    = req_chan.sample_valid;
               state_in = ocvs_pkg::ST_CHECK;
            end
         end
         ocvs_pkg::ST_CHECK: begin
            state_in      = ocvs_pkg::ST_HOLD;
            res_soc_in    = '0;
            res_status_in = ocvs_pkg::RANGE_INTERP;
            if (!sv_ff) begin
               res_soc_in = '0;
            end else if (volt_ff < thr_ff) begin
               res_status_in = ocvs_pkg::RANGE_UNDER;
            end else if (SHORT_TABLE) begin
               res_soc_in    = ocvs_pkg::SOC_FULL;
               res_status_in = ocvs_pkg::RANGE_ABOVE;
            end else if (volt_ff < ocvs_pkg::ROM_VOLT[0]) begin
               res_status_in = ocvs_pkg::RANGE_BELOW;
            end else if (volt_ff >= ocvs_pkg::ROM_VOLT[LAST_INDEX]) begin
               res_soc_in    = ocvs_pkg::SOC_FULL;
               res_status_in = ocvs_pkg::RANGE_ABOVE;
            end else begin
               search_cmd.start = 1'b1;
               state_in         = ocvs_pkg::ST_SEARCH;
            end
         end
         ocvs_pkg::ST_SEARCH: begin
            if (search_rsp.done) begin
               arith_cmd.start = 1'b1;
               state_in        = ocvs_pkg::ST_ARITH;
            end
         end
         ocvs_pkg::ST_ARITH: begin
            if (arith_rsp.done) begin
               res_soc_in    = arith_rsp.soc;
               res_status_in = ocvs_pkg::RANGE_INTERP;
               state_in      = ocvs_pkg::ST_HOLD;
            end
         end
         ocvs_pkg::ST_HOLD: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = ocvs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ocvs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_soc_in    = out_soc_ff;
      out_sv_in     = out_sv_ff;
      out_status_in = out_status_ff;
      if (load_out) begin
         out_valid_in  = 1'b1;
         out_soc_in    = res_soc_ff;
         out_sv_in     = sv_ff;
         out_status_in = res_status_ff;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ocvs_pkg::ST_IDLE;
         thr_ff       <= ocvs_pkg::UV_DEFAULT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         out_valid_ff <= out_valid_in;
      end
      volt_ff       <= volt_in;
      sv_ff         <= sv_in;
      res_soc_ff    <= res_soc_in;
      res_status_ff <= res_status_in;
      out_soc_ff    <= out_soc_in;
      out_sv_ff     <= out_sv_in;
      out_status_ff <= out_status_in;
   end

   assign req_chan.ready        = (state_ff == ocvs_pkg::ST_IDLE);
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.soc_tenths   = out_soc_ff;
   assign rsp_chan.soc_valid    = out_sv_ff;
   assign rsp_chan.range_status = out_status_ff;

   a_search_done_state: assert property (@(posedge clock) disable iff (reset)
      search_rsp.done |-> (state_ff == ocvs_pkg::ST_SEARCH))
      else $error("search finished outside search state");

   a_arith_done_state: assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> (state_ff == ocvs_pkg::ST_ARITH))
      else $error("arith finished outside arith state");

   a_segment_in_table: assert property (@(posedge clock) disable iff (reset)
      search_rsp.done |-> (search_rsp.index < LAST_INDEX))
      else $error("segment beyond last table point");

   a_soc_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.soc_tenths <= ocvs_pkg::SOC_FULL))
      else $error("charge above full");

   // an invalid sample answers all zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.soc_valid) |->
      (rsp_chan.soc_tenths == '0 && rsp_chan.range_status == ocvs_pkg::RANGE_INTERP))
      else $error("invalid sample with non-zero result");

endmodule
